// File: design/lct_pkg.sv
// ---------------------------------------------------------------------------
// LRU cache table package
// Request, result and cell types shared by the cache table and its cells.
// ---------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_res_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic prev_valid;
    logic evict;
    logic next_pre;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic valid_pre;
    logic match;
  } cell_sts_t;

endpackage

// File: design/lct_cell.sv
// ---------------------------------------------------------------------------
// LRU cache table cell
// One entry of the recency-ordered chain. It compares its key with the
// request and takes its upstream neighbor's entry when the chain shifts.
// ---------------------------------------------------------------------------
module lct_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [lct_pkg::KEY_W-1:0] probe_key,
  input  lct_pkg::slot_t               prev_slot,
  input  lct_pkg::cell_ctl_t           ctl,
  output lct_pkg::slot_t               slot,
  output lct_pkg::cell_sts_t           sts
);

  lct_pkg::slot_t slot_r;
  lct_pkg::slot_t slot_nxt;
  logic           valid_r;
  logic           valid_pre;
  logic           valid_nxt;

  always_comb begin
    valid_pre = ctl.shift ? ctl.prev_valid : valid_r;
    valid_nxt = valid_pre & ~(ctl.evict & ~ctl.next_pre);
    slot_nxt  = ctl.shift ? prev_slot : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot          = slot_r;
  assign sts.valid     = valid_r;
  assign sts.valid_pre = valid_pre;
  assign sts.match     = valid_r && (slot_r.key == probe_key);

endmodule

// File: design/lru_cache_table.sv
// ---------------------------------------------------------------------------
// LRU cache table: one request per cycle unless stalled; a get returns its
// result in the cycle after acceptance, a put gives no result. Entries sit in
// recency order, the most recent in the first cell; the chain shifts as one.
// Synchronous reset empties every entry and sets capacity to sixteen.
// ---------------------------------------------------------------------------
module lru_cache_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lct_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lct_pkg::out_res_t             out_res,
  input  logic                          cfg_wr_en,
  input  logic [lct_pkg::CAP_W-1:0]     cfg_wr_data
);

  localparam int unsigned XW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMW = (XW > lct_pkg::CAP_W) ? XW : lct_pkg::CAP_W;
  localparam logic [CMW-1:0] MAX_C = CMW'(MAX_ENTRIES);

  logic [lct_pkg::CAP_W-1:0] cap_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  lct_pkg::out_res_t         out_res_r;
  lct_pkg::out_res_t         out_res_nxt;

  lct_pkg::slot_t            cell_slot [MAX_ENTRIES];
  lct_pkg::slot_t            prev_slot [MAX_ENTRIES];
  lct_pkg::cell_ctl_t        ctl       [MAX_ENTRIES];
  lct_pkg::cell_sts_t        sts       [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]    vld;
  logic [MAX_ENTRIES-1:0]    match;
  logic [MAX_ENTRIES:0]      vext;
  logic                      acc;
  logic                      hit;
  logic                      evict;
  logic signed [lct_pkg::VAL_W-1:0] hit_value;
  lct_pkg::slot_t            front;
  logic [CMW-1:0]            cap_ext;
  logic [CMW-1:0]            cap_eff;
  logic [CMW:0]              ev_idx;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      vld[i]   = sts[i].valid;
      match[i] = sts[i].match;
    end
    hit       = |match;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_value = hit_value | (cell_slot[i].value & {lct_pkg::VAL_W{match[i]}});
    end
    front.key   = in_req.key;
    front.value = (in_req.op == lct_pkg::OP_PUT) ? in_req.value : hit_value;

    cap_ext = CMW'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMW'(1);
    end else if (cap_ext > MAX_C) begin
      cap_eff = MAX_C;
    end else begin
      cap_eff = cap_ext;
    end
    vext   = {1'b0, vld};
    ev_idx = {1'b0, cap_eff} + (CMW + 1)'(hit) - (CMW + 1)'(1);
    // A new key pushed into a full chain drops the last entry by the shift.
    evict  = acc && (in_req.op == lct_pkg::OP_PUT) && vext[XW'(ev_idx)]
             && (hit || !vld[MAX_ENTRIES-1]);

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      prev_slot[i]      = (i == 0) ? front : cell_slot[(i == 0) ? 0 : i - 1];
      ctl[i].prev_valid = (i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1];
      ctl[i].shift      = acc && (hit ? ((match >> i) != '0)
                                      : (in_req.op == lct_pkg::OP_PUT));
      ctl[i].evict      = evict;
      ctl[i].next_pre   = (i == MAX_ENTRIES - 1) ? 1'b0
                          : sts[(i == MAX_ENTRIES - 1) ? i : i + 1].valid_pre;
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lct_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe_key (in_req.key),
      .prev_slot (prev_slot[g]),
      .ctl       (ctl[g]),
      .slot      (cell_slot[g]),
      .sts       (sts[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (acc && (in_req.op == lct_pkg::OP_GET)) begin
      out_valid_nxt          = 1'b1;
      out_res_nxt.hit        = hit;
      out_res_nxt.read_value = hit ? hit_value : '1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cap_r       <= lct_pkg::CAP_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld + MAX_ENTRIES'(1)) & vld) == '0)
    else $error("Valid entries are not packed toward the front.");

  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("More than one entry matches the request key.");

  a_put_front: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.op == lct_pkg::OP_PUT) |=>
      vld[0] && (cell_slot[0].key == $past(in_req.key))
      && (cell_slot[0].value == $past(in_req.value)))
    else $error("A put request did not land in the front entry.");

  a_hit_front: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.op == lct_pkg::OP_GET) && hit |=>
      vld[0] && (cell_slot[0].key == $past(in_req.key)))
    else $error("A get hit did not move its entry to the front.");

  a_miss_stable: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.op == lct_pkg::OP_GET) && !hit |=> $stable(vld))
    else $error("A get miss changed the set of valid entries.");

endmodule
